// File: sv/assert_macros.svh
// Assertion macros used by the port checker file. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// File: sv/mndf_pkg.sv
`default_nettype none

package mndf_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BREAK,
    PH_MARK,
    PH_DATA
  } phase_t;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BREAK_TICKS = 2'd0;
  localparam cfg_idx_t CFG_MARK_TICKS  = 2'd1;
  localparam cfg_idx_t CFG_START_CODE  = 2'd2;

  localparam logic [7:0] BREAK_TICKS_RESET = 8'd22;
  localparam logic [7:0] MARK_TICKS_RESET  = 8'd2;
  localparam logic [7:0] START_CODE_RESET  = 8'd0;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

  localparam logic [3:0] BITS_PER_BYTE = 4'd11;
  localparam logic [3:0] LAST_DATA_BIT = 4'd8;

  // Serial line level for a given frame position: start bit low, data LSB first,
  // stop bits and idle high, break low.
  function automatic logic line_level(input phase_t phase, input logic [3:0] bit_idx,
                                      input logic [7:0] shift);
    logic lvl;
    lvl = 1'b1;
    case (phase)
      PH_BREAK: lvl = 1'b0;
      PH_DATA: begin
        if (bit_idx == 4'd0) begin
          lvl = 1'b0;
        end else if (bit_idx <= LAST_DATA_BIT) begin
          lvl = shift[3'(bit_idx - 4'd1)];
        end
      end
      default: lvl = 1'b1;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: sv/mndf_slot_mem.sv
`default_nettype none

module mndf_slot_mem #(
  parameter int DEPTH = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Write-first read: a write to the address being read shows up at once.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: sv/midi_note_to_dmx_framer.sv
// Each result is registered and appears on the output in the cycle after its input transaction.
// Throughput: one input transaction per cycle while the table is not clearing and the output is not stalled;
// each tick input is one DMX bit period. The slot table is a single-port-write memory whose registered read
// is addressed by the next slot index, ahead of each byte load. Reset is synchronous and active low. After reset
// a sweep over all SLOT_COUNT addresses zeroes the slot table while in_ready stays low; configuration writes are taken.
`default_nettype none

module midi_note_to_dmx_framer #(
  parameter int SLOT_COUNT = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_status_byte,
  input  wire logic [6:0] in_note_number,
  input  wire logic [6:0] in_note_velocity,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_line_level,
  output logic            out_frame_busy
);

  localparam int ADDR_W = $clog2(SLOT_COUNT);
  localparam int SLOT_W = $clog2(SLOT_COUNT + 1);

  logic [7:0] break_ticks_r;
  logic [7:0] mark_ticks_r;
  logic [7:0] start_code_r;

  mndf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              pending_r, pending_nxt;
  logic [6:0]        highest_r, highest_nxt;

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic       out_valid_r;
  logic       out_level_r, out_level_nxt;
  logic       out_busy_r, out_busy_nxt;

  logic              accept;
  logic              cmd_ok;
  logic              note_ok;
  logic              evt_write;
  logic [7:0]        evt_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [3:0]        bit_inc;
  logic [7:0]        cnt_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clearing_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;

  assign cmd_ok  = (in_status_byte[7:4] == mndf_pkg::CMD_NOTE_ON) ||
                   (in_status_byte[7:4] == mndf_pkg::CMD_NOTE_OFF);
  assign note_ok = 32'(in_note_number) < SLOT_COUNT;
  assign evt_write = accept && (in_operation == mndf_pkg::OP_EVENT) && cmd_ok && note_ok;
  assign evt_data  = (in_status_byte[7:4] == mndf_pkg::CMD_NOTE_ON) ?
                     {in_note_velocity, 1'b0} : 8'd0;

  assign mem_we    = clearing_r || evt_write;
  assign mem_waddr = clearing_r ? clr_addr_r : ADDR_W'(in_note_number);
  assign mem_wdata = clearing_r ? 8'd0 : evt_data;
  assign mem_raddr = (32'(slot_nxt) < SLOT_COUNT) ? ADDR_W'(slot_nxt) : '0;

  mndf_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .ADDR_W(ADDR_W)
  ) u_slot_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign bit_inc = bit_r + 4'd1;
  assign cnt_inc = cnt_r + 8'd1;

  // Next frame state.
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    bit_nxt     = bit_r;
    slot_nxt    = slot_r;
    shift_nxt   = shift_r;
    pending_nxt = pending_r;
    highest_nxt = highest_r;
    if (accept) begin
      if (in_operation == mndf_pkg::OP_EVENT) begin
        if (cmd_ok && note_ok) begin
          if (in_note_number > highest_r) begin
            highest_nxt = in_note_number;
          end
          if (phase_r == mndf_pkg::PH_IDLE) begin
            phase_nxt = mndf_pkg::PH_BREAK;
            cnt_nxt   = 8'd0;
            bit_nxt   = 4'd0;
            slot_nxt  = '0;
          end else begin
            pending_nxt = 1'b1;
          end
        end
      end else begin
        case (phase_r)
          mndf_pkg::PH_BREAK: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= break_ticks_r) begin
              phase_nxt = mndf_pkg::PH_MARK;
              cnt_nxt   = 8'd0;
            end
          end
          mndf_pkg::PH_MARK: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= mark_ticks_r) begin
              phase_nxt = mndf_pkg::PH_DATA;
              cnt_nxt   = 8'd0;
              bit_nxt   = 4'd0;
              slot_nxt  = '0;
              shift_nxt = start_code_r;
            end
          end
          mndf_pkg::PH_DATA: begin
            bit_nxt = bit_inc;
            if (bit_inc >= mndf_pkg::BITS_PER_BYTE) begin
              bit_nxt = 4'd0;
              if ((32'(slot_r) <= 32'(highest_r)) && (32'(slot_r) < SLOT_COUNT)) begin
                shift_nxt = mem_rdata;
                slot_nxt  = slot_r + SLOT_W'(1);
              end else if (pending_r) begin
                pending_nxt = 1'b0;
                phase_nxt   = mndf_pkg::PH_BREAK;
                cnt_nxt     = 8'd0;
                slot_nxt    = '0;
              end else begin
                phase_nxt = mndf_pkg::PH_IDLE;
                slot_nxt  = '0;
              end
            end
          end
          default: phase_nxt = mndf_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Result: a tick reports the period it drives, an event the coming period.
  always_comb begin
    if (in_operation == mndf_pkg::OP_EVENT) begin
      out_level_nxt = mndf_pkg::line_level(phase_nxt, bit_nxt, shift_nxt);
      out_busy_nxt  = phase_nxt != mndf_pkg::PH_IDLE;
    end else begin
      out_level_nxt = mndf_pkg::line_level(phase_r, bit_r, shift_r);
      out_busy_nxt  = phase_r != mndf_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_ticks_r <= mndf_pkg::BREAK_TICKS_RESET;
      mark_ticks_r  <= mndf_pkg::MARK_TICKS_RESET;
      start_code_r  <= mndf_pkg::START_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mndf_pkg::CFG_BREAK_TICKS: break_ticks_r <= cfg_data;
        mndf_pkg::CFG_MARK_TICKS:  mark_ticks_r  <= cfg_data;
        mndf_pkg::CFG_START_CODE:  start_code_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mndf_pkg::PH_IDLE;
      cnt_r      <= 8'd0;
      bit_r      <= 4'd0;
      slot_r     <= '0;
      shift_r    <= 8'd0;
      pending_r  <= 1'b0;
      highest_r  <= 7'd0;
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      bit_r     <= bit_nxt;
      slot_r    <= slot_nxt;
      shift_r   <= shift_nxt;
      pending_r <= pending_nxt;
      highest_r <= highest_nxt;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(SLOT_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r <= out_level_nxt;
      out_busy_r  <= out_busy_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_level_r;
  assign out_frame_busy = out_busy_r;

endmodule

`default_nettype wire

// File: sv/mndf_port_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mndf_port_checker #(
  parameter int SLOT_COUNT = 128
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_operation,
  input wire logic [7:0] in_status_byte,
  input wire logic [6:0] in_note_number,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_line_level,
  input wire logic       out_frame_busy
);

  logic in_acc;
  logic out_wait;
  logic note_cmd;
  logic note_evt;

  assign in_acc   = in_valid && in_ready;
  assign out_wait = out_valid && !out_ready;
  assign note_cmd = (in_status_byte[7:4] == mndf_pkg::CMD_NOTE_ON) ||
                    (in_status_byte[7:4] == mndf_pkg::CMD_NOTE_OFF);
  assign note_evt = in_acc && (in_operation == mndf_pkg::OP_EVENT) && note_cmd &&
                    (32'(in_note_number) < SLOT_COUNT);

  // A result that is not taken stays on the port unchanged.
  `ASSERT_NEXT_CYCLE(a_out_hold, out_wait, out_valid && $stable({out_line_level, out_frame_busy}))

  // Every accepted input transaction yields a result in the next cycle.
  `ASSERT_NEXT_CYCLE(a_result_follows, in_acc, out_valid)

  // A note on or note off for a slot in the table always leaves a frame running.
  `ASSERT_NEXT_CYCLE(a_note_starts_frame, note_evt, out_valid && out_frame_busy)

  // With no frame running the line sits high.
  `ASSERT_SAME_CYCLE(a_idle_high, out_valid && !out_frame_busy, out_line_level)

endmodule

bind midi_note_to_dmx_framer mndf_port_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_operation  (in_operation),
  .in_status_byte(in_status_byte),
  .in_note_number(in_note_number),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_line_level(out_line_level),
  .out_frame_busy(out_frame_busy)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SLOTS = 128;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       op;
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
  } midi_item_t;

  typedef struct packed {
    logic level;
    logic busy;
  } dmx_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_operation = 1'b0;
  logic [7:0] in_status_byte = '0;
  logic [6:0] in_note_number = '0;
  logic [6:0] in_note_velocity = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_line_level;
  logic       out_frame_busy;

  midi_note_to_dmx_framer #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_status_byte  (in_status_byte),
    .in_note_number  (in_note_number),
    .in_note_velocity(in_note_velocity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_level  (out_line_level),
    .out_frame_busy  (out_frame_busy)
  );

  always #5 clk = ~clk;

  midi_item_t pending_items[$];
  dmx_out_t   expected_line[$];
  int         fail_count = 0;
  logic       no_idle = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         long_hold_left = 0;
  int         hold_requested = 0;
  int         hold_served = 0;

  logic [7:0]         brk_len;
  logic [7:0]         mab_len;
  logic [7:0]         start_byte;
  logic [7:0]         slot_mem[SLOTS];
  logic [6:0]         top_slot;
  mndf_pkg::phase_t   model_phase;
  logic [7:0]         phase_cnt;
  logic [3:0]         bit_pos;
  logic [7:0]         slot_pos;
  logic [7:0]         shift_reg;
  logic               pend;

  function automatic logic level_now();
    if (model_phase == mndf_pkg::PH_BREAK) return 1'b0;
    if (model_phase == mndf_pkg::PH_DATA) begin
      if (bit_pos == 4'd0) return 1'b0;
      if (bit_pos <= mndf_pkg::LAST_DATA_BIT) return shift_reg[3'(bit_pos - 4'd1)];
    end
    return 1'b1;
  endfunction

  task automatic start_frame();
    model_phase = mndf_pkg::PH_BREAK;
    phase_cnt = '0;
    bit_pos = '0;
    slot_pos = '0;
  endtask

  task automatic advance_bit_period();
    case (model_phase)
      mndf_pkg::PH_BREAK: begin
        phase_cnt = phase_cnt + 8'd1;
        if (phase_cnt >= brk_len) begin
          model_phase = mndf_pkg::PH_MARK;
          phase_cnt = '0;
        end
      end
      mndf_pkg::PH_MARK: begin
        phase_cnt = phase_cnt + 8'd1;
        if (phase_cnt >= mab_len) begin
          model_phase = mndf_pkg::PH_DATA;
          phase_cnt = '0;
          bit_pos = '0;
          slot_pos = '0;
          shift_reg = start_byte;
        end
      end
      mndf_pkg::PH_DATA: begin
        bit_pos = bit_pos + 4'd1;
        if (bit_pos >= mndf_pkg::BITS_PER_BYTE) begin
          bit_pos = '0;
          if (slot_pos <= {1'b0, top_slot} && slot_pos < SLOTS) begin
            shift_reg = slot_mem[SLOT_AW'(slot_pos)];
            slot_pos = slot_pos + 8'd1;
          end else if (pend) begin
            pend = 1'b0;
            start_frame();
          end else begin
            model_phase = mndf_pkg::PH_IDLE;
            slot_pos = '0;
          end
        end
      end
      default: model_phase = mndf_pkg::PH_IDLE;
    endcase
  endtask

  task automatic predict_dmx_step(input midi_item_t it);
    logic [3:0] cmd;
    dmx_out_t   res;
    cmd = it.status[7:4];
    if (it.op == mndf_pkg::OP_EVENT) begin
      if ((cmd == mndf_pkg::CMD_NOTE_ON || cmd == mndf_pkg::CMD_NOTE_OFF) &&
          (32'(it.note) < SLOTS)) begin
        slot_mem[SLOT_AW'(it.note)] = (cmd == mndf_pkg::CMD_NOTE_ON) ? {it.vel, 1'b0} : 8'd0;
        if (it.note > top_slot) top_slot = it.note;
        if (model_phase == mndf_pkg::PH_IDLE) start_frame();
        else pend = 1'b1;
      end
      res.level = level_now();
      res.busy = (model_phase != mndf_pkg::PH_IDLE);
    end else begin
      res.level = level_now();
      res.busy = (model_phase != mndf_pkg::PH_IDLE);
      advance_bit_period();
    end
    expected_line.push_back(res);
  endtask

  function automatic midi_item_t rand_midi_item(int tick_pct, int note_max);
    midi_item_t it;
    int         pick;
    logic [3:0] nib;
    it.status = 8'($urandom_range(0, 255));
    it.note = 7'($urandom_range(0, 127));
    it.vel = 7'($urandom_range(0, 127));
    it.op = mndf_pkg::OP_TICK;
    if ($urandom_range(0, 99) < tick_pct) return it;
    it.op = mndf_pkg::OP_EVENT;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.status[7:4] = mndf_pkg::CMD_NOTE_ON;
      it.note = 7'($urandom_range(0, note_max));
    end else if (pick < 80) begin
      it.status[7:4] = mndf_pkg::CMD_NOTE_OFF;
      it.note = 7'($urandom_range(0, note_max));
    end else begin
      nib = 4'($urandom_range(0, 13));
      if (nib >= mndf_pkg::CMD_NOTE_OFF) nib = nib + 4'd2;
      it.status[7:4] = nib;
    end
    return it;
  endfunction

  // The prediction for an input transaction is made at the edge that accepts it.
  always @(posedge clk) begin : feed_items
    midi_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_dmx_step('{in_operation, in_status_byte, in_note_number, in_note_velocity});
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!no_idle && $urandom_range(0, 15) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 8);
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_operation <= nxt.op;
          in_status_byte <= nxt.status;
          in_note_number <= nxt.note;
          in_note_velocity <= nxt.vel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : long_hold
    if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
    end else if (hold_served != hold_requested) begin
      long_hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_line
    dmx_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_line.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: line_level %0b frame_busy %0b",
                   out_line_level, out_frame_busy);
        end
        fail_count++;
      end else begin
        want = expected_line.pop_front();
        if (out_line_level !== want.level) begin
          if (fail_count < 10) begin
            $display("line_level mismatch: expected %0b got %0b", want.level, out_line_level);
          end
          fail_count++;
        end
        if (out_frame_busy !== want.busy) begin
          if (fail_count < 10) begin
            $display("frame_busy mismatch: expected %0b got %0b", want.busy, out_frame_busy);
          end
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input mndf_pkg::cfg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mndf_pkg::CFG_BREAK_TICKS: brk_len = val;
      mndf_pkg::CFG_MARK_TICKS:  mab_len = val;
      mndf_pkg::CFG_START_CODE:  start_byte = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_items.size() != 0 || in_valid || expected_line.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] brk, input logic [7:0] mab, input logic [7:0] sc,
                           input int count, input int tick_pct, input logic hold);
    write_reg(mndf_pkg::CFG_BREAK_TICKS, brk);
    write_reg(mndf_pkg::CFG_MARK_TICKS, mab);
    write_reg(mndf_pkg::CFG_START_CODE, sc);
    repeat (count) pending_items.push_back(rand_midi_item(tick_pct, 7));
    if (hold) hold_requested++;
    wait_drained();
  endtask

  initial begin : run_test
    brk_len = mndf_pkg::BREAK_TICKS_RESET;
    mab_len = mndf_pkg::MARK_TICKS_RESET;
    start_byte = mndf_pkg::START_CODE_RESET;
    for (int i = 0; i < SLOTS; i++) slot_mem[SLOT_AW'(i)] = 8'd0;
    top_slot = '0;
    model_phase = mndf_pkg::PH_IDLE;
    phase_cnt = '0;
    bit_pos = '0;
    slot_pos = '0;
    shift_reg = '0;
    pend = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_items.push_back('{mndf_pkg::OP_TICK, 8'hFF, 7'h7F, 7'h7F});
    pending_items.push_back('{mndf_pkg::OP_TICK, 8'h00, 7'h00, 7'h00});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h00, 7'd127, 7'd127});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h7F, 7'd5, 7'd9});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'hA0, 7'd6, 7'd9});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'hFF, 7'd0, 7'd0});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h90, 7'd0, 7'd127});
    pending_items.push_back('{mndf_pkg::OP_TICK, 8'h00, 7'h00, 7'h00});
    pending_items.push_back('{mndf_pkg::OP_TICK, 8'h00, 7'h00, 7'h00});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h9F, 7'd3, 7'd0});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h80, 7'd1, 7'd127});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h8F, 7'd2, 7'd1});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h95, 7'd4, 7'd64});
    pending_items.push_back('{mndf_pkg::OP_TICK, 8'h55, 7'h2A, 7'h55});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h90, 7'd0, 7'd1});
    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h7F, 7'd7, 7'd1});
    pending_items.push_back('{mndf_pkg::OP_TICK, 8'hAA, 7'h55, 7'h2A});
    wait_drained();

    run_phase(8'd1, 8'd1, 8'hFF, 150, 70, 1'b1);
    run_phase(8'd255, 8'd1, 8'hA5, 300, 85, 1'b0);
    run_phase(8'd1, 8'd255, 8'h00, 300, 85, 1'b0);
    no_idle = 1'b1;
    run_phase(8'd0, 8'd0, 8'($urandom_range(0, 255)), 100, 75, 1'b0);

    pending_items.push_back('{mndf_pkg::OP_EVENT, 8'h90, 7'd127, 7'd127});
    repeat (120) pending_items.push_back(rand_midi_item(100, 0));
    wait_drained();
    repeat (10) @(negedge clk);

    if (fail_count == 0 && expected_line.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
